/* sv/grid_maze_reachability_core_assert.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the grid maze reachability core
// Shorthand for clocked implication checks with an active-low reset.
// ----------------------------------------------------------------------------
`ifndef GRID_MAZE_REACHABILITY_CORE_ASSERT_SVH
`define GRID_MAZE_REACHABILITY_CORE_ASSERT_SVH

// same-cycle implication
`define GMR_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("gmr assertion failed");

// next-cycle implication
`define GMR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("gmr assertion failed");

`endif

/* sv/gmr_pkg.sv */
// ----------------------------------------------------------------------------
// gmr_pkg
// Shared constants for the grid maze reachability core.
// ----------------------------------------------------------------------------
`default_nettype none

package gmr_pkg;

	localparam int FIELD_W  = 4;   // width of row/col request fields
	localparam int DIM_W    = 7;   // holds any coordinate + 1 and any grid size
	localparam int EPOCH_W  = 8;   // visited-map epoch tag
	localparam int DEF_ROWS = 16;
	localparam int DEF_COLS = 16;

	localparam logic [1:0] DIR_LEFT  = 2'd0;
	localparam logic [1:0] DIR_UP    = 2'd1;
	localparam logic [1:0] DIR_RIGHT = 2'd2;
	localparam logic [1:0] DIR_DOWN  = 2'd3;

	localparam logic KIND_LOAD  = 1'b0;
	localparam logic KIND_QUERY = 1'b1;

endpackage

`default_nettype wire

/* sv/gmr_ram.sv */
// ----------------------------------------------------------------------------
// gmr_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
`default_nettype none

module gmr_ram #(
	parameter int ADDR_W = 8,
	parameter int DATA_W = 1
) (
	input  wire logic              clk,
	input  wire logic              we,
	input  wire logic [ADDR_W-1:0] waddr,
	input  wire logic [DATA_W-1:0] wdata,
	input  wire logic [ADDR_W-1:0] raddr,
	output logic      [DATA_W-1:0] rdata
);

	logic [DATA_W-1:0] mem [2**ADDR_W];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

/* sv/gmr_step_unit.sv */
// ----------------------------------------------------------------------------
// gmr_step_unit
// Shared neighbor step: one increment/decrement and one bound compare.
// ----------------------------------------------------------------------------
`default_nettype none

module gmr_step_unit import gmr_pkg::*; #(
	parameter  int GRID_ROWS = DEF_ROWS,
	parameter  int GRID_COLS = DEF_COLS,
	localparam int RW = $clog2(GRID_ROWS),
	localparam int CW = $clog2(GRID_COLS)
) (
	input  wire logic [RW-1:0] cur_row,
	input  wire logic [CW-1:0] cur_col,
	input  wire logic [1:0]    dir,
	output logic      [RW-1:0] nbr_row,
	output logic      [CW-1:0] nbr_col,
	output logic               in_grid
);

	logic             row_axis;
	logic             dec;
	logic [DIM_W-1:0] opnd;
	logic [DIM_W-1:0] limit;
	logic [DIM_W-1:0] sum;

	always_comb begin
		row_axis = (dir == DIR_UP) || (dir == DIR_DOWN);
		dec      = (dir == DIR_LEFT) || (dir == DIR_UP);
		opnd     = row_axis ? DIM_W'(cur_row) : DIM_W'(cur_col);
		limit    = row_axis ? DIM_W'(GRID_ROWS) : DIM_W'(GRID_COLS);
		sum      = dec ? (opnd - DIM_W'(1)) : (opnd + DIM_W'(1));
		in_grid  = dec ? (opnd != '0) : (sum < limit);
		nbr_row  = row_axis ? sum[RW-1:0] : cur_row;
		nbr_col  = row_axis ? cur_col : sum[CW-1:0];
	end

endmodule

`default_nettype wire

/* sv/grid_maze_reachability_core.sv */
// ----------------------------------------------------------------------------
// grid_maze_reachability_core
// Grid maze store with a depth-first reachability walk over a cell stack.
// ----------------------------------------------------------------------------
//  channel   handshake        payload
//  request   start / busy     kind, row, col, is_open, target_row, target_col
//  result    done (1 cycle)   reachable
//
//  Load, and a query with start == target or either cell off the grid, need no walk.
//  Walk: seed the stack, then per popped cell pop and compare with the target, then per
//  neighbor a grid-bound check and, for an in-grid neighbor, a map read and a possible push.
//  When the epoch tag runs out (every 255 walks) the walk first sweeps the visited
//  map, all 2**(RW+CW) entries.
//  After reset busy stays high for the same sweep while the maze is cleared to walls.
//  The receiver cannot stall: done is high for exactly one cycle per query.
// ----------------------------------------------------------------------------
`default_nettype none

module grid_maze_reachability_core import gmr_pkg::*; #(
	parameter int GRID_ROWS = DEF_ROWS,
	parameter int GRID_COLS = DEF_COLS
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	output logic                    busy,
	input  wire logic               kind,
	input  wire logic [FIELD_W-1:0] row,
	input  wire logic [FIELD_W-1:0] col,
	input  wire logic               is_open,
	input  wire logic [FIELD_W-1:0] target_row,
	input  wire logic [FIELD_W-1:0] target_col,
	output logic                    done,
	output logic                    reachable
);

	localparam int RW  = $clog2(GRID_ROWS);
	localparam int CW  = $clog2(GRID_COLS);
	localparam int AW  = RW + CW;
	localparam int SPW = AW + 1;

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_CLR  = 3'd1;
	localparam logic [2:0] ST_SEED = 3'd2;
	localparam logic [2:0] ST_POP  = 3'd3;
	localparam logic [2:0] ST_POPW = 3'd4;
	localparam logic [2:0] ST_NBA  = 3'd5;
	localparam logic [2:0] ST_NBC  = 3'd6;

	logic [2:0]         state_q;
	logic               clr_open_q;
	logic [AW-1:0]      clr_cnt_q;
	logic [EPOCH_W-1:0] epoch_q;
	logic [SPW-1:0]     sp_q;
	logic [1:0]         dir_q;
	logic               done_q;
	logic               reach_q;

	logic [RW-1:0]      st_r_q, tg_r_q, cur_r_q;
	logic [CW-1:0]      st_c_q, tg_c_q, cur_c_q;
	logic [AW-1:0]      nbr_q;

	logic               accept;
	logic               same_cell;
	logic               st_in, tg_in;
	logic [SPW-1:0]     sp_dec;
	logic [RW-1:0]      nbr_row;
	logic [CW-1:0]      nbr_col;
	logic               in_grid;
	logic               push;
	logic               hit;

	logic               open_we, vis_we, stk_we;
	logic [AW-1:0]      open_waddr, vis_waddr, stk_waddr;
	logic               open_wdata;
	logic [EPOCH_W-1:0] vis_wdata;
	logic [AW-1:0]      stk_wdata;
	logic               open_rd;
	logic [EPOCH_W-1:0] vis_rd;
	logic [AW-1:0]      stk_rd;

	assign busy      = (state_q != ST_IDLE);
	assign accept    = start && !busy;
	assign done      = done_q;
	assign reachable = reach_q;

	assign same_cell = (row == target_row) && (col == target_col);
	assign st_in     = (DIM_W'(row) < DIM_W'(GRID_ROWS)) && (DIM_W'(col) < DIM_W'(GRID_COLS));
	assign tg_in     = (DIM_W'(target_row) < DIM_W'(GRID_ROWS))
	                && (DIM_W'(target_col) < DIM_W'(GRID_COLS));
	assign sp_dec    = sp_q - SPW'(1);
	assign push      = open_rd && (vis_rd != epoch_q);
	assign hit       = (stk_rd == {tg_r_q, tg_c_q});

	gmr_step_unit #(
		.GRID_ROWS(GRID_ROWS),
		.GRID_COLS(GRID_COLS)
	) u_step (
		.cur_row(cur_r_q),
		.cur_col(cur_c_q),
		.dir    (dir_q),
		.nbr_row(nbr_row),
		.nbr_col(nbr_col),
		.in_grid(in_grid)
	);

	// write port steering
	always_comb begin
		open_we    = (state_q == ST_CLR && clr_open_q)
		          || (accept && kind == KIND_LOAD && st_in);
		open_waddr = (state_q == ST_CLR) ? clr_cnt_q : {RW'(row), CW'(col)};
		open_wdata = (state_q == ST_CLR) ? 1'b0 : is_open;

		vis_we     = (state_q == ST_CLR) || (state_q == ST_SEED)
		          || (state_q == ST_NBC && push);
		case (state_q)
			ST_CLR:  vis_waddr = clr_cnt_q;
			ST_SEED: vis_waddr = {st_r_q, st_c_q};
			default: vis_waddr = nbr_q;
		endcase
		vis_wdata  = (state_q == ST_CLR) ? '0 : epoch_q;

		stk_we     = (state_q == ST_SEED) || (state_q == ST_NBC && push);
		stk_waddr  = (state_q == ST_SEED) ? '0 : sp_q[AW-1:0];
		stk_wdata  = (state_q == ST_SEED) ? {st_r_q, st_c_q} : nbr_q;
	end

	gmr_ram #(.ADDR_W(AW), .DATA_W(1)) u_open_map (
		.clk  (clk),
		.we   (open_we),
		.waddr(open_waddr),
		.wdata(open_wdata),
		.raddr({nbr_row, nbr_col}),
		.rdata(open_rd)
	);

	gmr_ram #(.ADDR_W(AW), .DATA_W(EPOCH_W)) u_visited_map (
		.clk  (clk),
		.we   (vis_we),
		.waddr(vis_waddr),
		.wdata(vis_wdata),
		.raddr({nbr_row, nbr_col}),
		.rdata(vis_rd)
	);

	gmr_ram #(.ADDR_W(AW), .DATA_W(AW)) u_walk_stack (
		.clk  (clk),
		.we   (stk_we),
		.waddr(stk_waddr),
		.wdata(stk_wdata),
		.raddr(sp_dec[AW-1:0]),
		.rdata(stk_rd)
	);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_CLR;
			clr_open_q <= 1'b1;
			clr_cnt_q  <= '0;
			epoch_q    <= '0;
			sp_q       <= '0;
			dir_q      <= DIR_LEFT;
			done_q     <= 1'b0;
			reach_q    <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (accept && kind == KIND_QUERY) begin
						if (same_cell) begin
							done_q  <= 1'b1;
							reach_q <= 1'b1;
						end else if (!st_in || !tg_in) begin
							done_q  <= 1'b1;
							reach_q <= 1'b0;
						end else if (&epoch_q) begin
							// tags exhausted: wipe visited map first
							clr_cnt_q <= '0;
							state_q   <= ST_CLR;
						end else begin
							epoch_q <= epoch_q + EPOCH_W'(1);
							state_q <= ST_SEED;
						end
					end
				end
				ST_CLR: begin
					clr_cnt_q <= clr_cnt_q + AW'(1);
					if (&clr_cnt_q) begin
						if (clr_open_q) begin
							clr_open_q <= 1'b0;
							state_q    <= ST_IDLE;
						end else begin
							epoch_q <= EPOCH_W'(1);
							state_q <= ST_SEED;
						end
					end
				end
				ST_SEED: begin
					sp_q    <= SPW'(1);
					state_q <= ST_POP;
				end
				ST_POP: begin
					if (sp_q == '0) begin
						done_q  <= 1'b1;
						reach_q <= 1'b0;
						state_q <= ST_IDLE;
					end else begin
						sp_q    <= sp_dec;
						state_q <= ST_POPW;
					end
				end
				ST_POPW: begin
					if (hit) begin
						done_q  <= 1'b1;
						reach_q <= 1'b1;
						state_q <= ST_IDLE;
					end else begin
						dir_q   <= DIR_LEFT;
						state_q <= ST_NBA;
					end
				end
				ST_NBA: begin
					if (in_grid) begin
						state_q <= ST_NBC;
					end else if (dir_q == DIR_DOWN) begin
						state_q <= ST_POP;
					end else begin
						dir_q <= dir_q + 2'd1;
					end
				end
				ST_NBC: begin
					if (push) begin
						sp_q <= sp_q + SPW'(1);
					end
					if (dir_q == DIR_DOWN) begin
						state_q <= ST_POP;
					end else begin
						dir_q   <= dir_q + 2'd1;
						state_q <= ST_NBA;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// walk payload registers
	always_ff @(posedge clk) begin
		if (accept) begin
			st_r_q <= RW'(row);
			st_c_q <= CW'(col);
			tg_r_q <= RW'(target_row);
			tg_c_q <= CW'(target_col);
		end
		if (state_q == ST_POPW) begin
			cur_r_q <= stk_rd[AW-1:CW];
			cur_c_q <= stk_rd[CW-1:0];
		end
		if (state_q == ST_NBA) begin
			nbr_q <= {nbr_row, nbr_col};
		end
	end

endmodule

`default_nettype wire

/* sv/gmr_checker.sv */
// ----------------------------------------------------------------------------
// gmr_checker
// Port-level checks on the grid maze reachability core, bound to the top.
// ----------------------------------------------------------------------------
`default_nettype none

`include "grid_maze_reachability_core_assert.svh"

module gmr_checker import gmr_pkg::*; (
	input wire logic               clk,
	input wire logic               arst_n,
	input wire logic               start,
	input wire logic               busy,
	input wire logic               kind,
	input wire logic [FIELD_W-1:0] row,
	input wire logic [FIELD_W-1:0] col,
	input wire logic [FIELD_W-1:0] target_row,
	input wire logic [FIELD_W-1:0] target_col,
	input wire logic               done,
	input wire logic               reachable
);

	logic load_req;
	logic self_query;

	assign load_req   = start && !busy && (kind == KIND_LOAD);
	assign self_query = start && !busy && (kind == KIND_QUERY)
	                 && (row == target_row) && (col == target_col);

	// a load request never produces a result
	`GMR_ASSERT_NEXT(a_load_no_result, clk, arst_n, load_req, !done)
	// a query whose start is its target answers reachable in the next cycle
	`GMR_ASSERT_NEXT(a_self_reach, clk, arst_n, self_query, done && reachable)
	// a result always leaves the core ready
	`GMR_ASSERT_NOW(a_done_idle, clk, arst_n, done, !busy)
	// only a query request can make the core busy
	`GMR_ASSERT_NOW(a_busy_by_query, clk, arst_n, $rose(busy),
		$past(start) && ($past(kind) == KIND_QUERY))

endmodule

bind grid_maze_reachability_core gmr_checker u_gmr_checker (.*);

`default_nettype wire
